FILE: src/rlfr_pkg.sv
`timescale 1ns / 1ps
`default_nettype none
package rlfr_pkg;

    localparam int RING_WORDS   = 17;
    localparam int SECOND_START = 10;
    localparam int PTR_W        = $clog2(RING_WORDS);
    localparam int WORD_W       = 32;
    localparam int ROT_SECOND   = 13;
    localparam int ROT_FIRST    = 9;
    localparam logic [WORD_W-1:0] SEED_MULT = 32'd2891336453;

    localparam logic [PTR_W-1:0] FIRST_INIT  = '0;
    localparam logic [PTR_W-1:0] SECOND_INIT = PTR_W'(SECOND_START % RING_WORDS);
    localparam logic [PTR_W-1:0] LAST_POS    = PTR_W'(RING_WORDS - 1);

    localparam int QUEUE_DEPTH = 2;
    localparam int QPTR_W      = (QUEUE_DEPTH > 1) ? $clog2(QUEUE_DEPTH) : 1;
    localparam int QCNT_W      = $clog2(QUEUE_DEPTH + 1);

    localparam int DIV_CNT_W = $clog2(WORD_W + 1);

    localparam logic CMD_RESEED = 1'b0;
    localparam logic CMD_DRAW   = 1'b1;

    // classified request: data holds the seed on reseed, the bound on draw
    typedef struct packed {
        logic              is_draw;
        logic              bound_zero;
        logic [WORD_W-1:0] data;
    } t_item;

    function automatic logic [WORD_W-1:0] rot_left(input logic [WORD_W-1:0] v);
        return (v << ROT_SECOND) | (v >> (WORD_W - ROT_SECOND));
    endfunction

    function automatic logic [WORD_W-1:0] rot_right(input logic [WORD_W-1:0] v);
        return (v >> ROT_FIRST) | (v << (WORD_W - ROT_FIRST));
    endfunction

    function automatic logic [PTR_W-1:0] step_down(input logic [PTR_W-1:0] pos);
        return (pos == '0) ? LAST_POS : pos - PTR_W'(1);
    endfunction

endpackage
`default_nettype wire

FILE: src/rlfr_front.sv
`timescale 1ns / 1ps
`default_nettype none
module rlfr_front (
    input  wire logic                   i_clk,
    input  wire logic                   i_rst_n,
    input  wire logic                   start,
    output logic                        busy,
    input  wire logic                   i_command,
    input  wire logic [31:0]            i_seed_value,
    input  wire logic [31:0]            i_bound,
    output logic                        o_q_valid,
    output rlfr_pkg::t_item             o_q_item,
    input  wire logic                   i_q_pop
);
    import rlfr_pkg::*;

    t_item              r_q [QUEUE_DEPTH];
    logic [QPTR_W-1:0]  r_wr_ptr;
    logic [QPTR_W-1:0]  r_rd_ptr;
    logic [QCNT_W-1:0]  r_cnt;
    logic               push;
    logic               pop;
    t_item              item_in;

    assign busy      = (r_cnt == QCNT_W'(QUEUE_DEPTH));
    assign push      = start && !busy;
    assign pop       = i_q_pop && (r_cnt != '0);
    assign o_q_valid = (r_cnt != '0);
    assign o_q_item  = r_q[r_rd_ptr];

    always_comb begin
        item_in.is_draw    = (i_command == CMD_DRAW);
        item_in.bound_zero = (i_bound == '0);
        item_in.data       = (i_command == CMD_DRAW) ? i_bound : i_seed_value;
    end

    always_ff @(posedge i_clk) begin
        if (push) begin
            r_q[r_wr_ptr] <= item_in;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_wr_ptr <= '0;
            r_rd_ptr <= '0;
            r_cnt    <= '0;
        end else begin
            if (push) begin
                r_wr_ptr <= (r_wr_ptr == QPTR_W'(QUEUE_DEPTH - 1)) ? '0 : r_wr_ptr + QPTR_W'(1);
            end
            if (pop) begin
                r_rd_ptr <= (r_rd_ptr == QPTR_W'(QUEUE_DEPTH - 1)) ? '0 : r_rd_ptr + QPTR_W'(1);
            end
            if (push && !pop) begin
                r_cnt <= r_cnt + QCNT_W'(1);
            end else if (pop && !push) begin
                r_cnt <= r_cnt - QCNT_W'(1);
            end
        end
    end

endmodule
`default_nettype wire

FILE: src/rlfr_div.sv
`timescale 1ns / 1ps
`default_nettype none
module rlfr_div (
    input  wire logic        i_clk,
    input  wire logic        i_rst_n,
    input  wire logic        i_start,
    input  wire logic [31:0] i_dividend,
    input  wire logic [31:0] i_divisor,
    output logic             o_done,
    output logic [31:0]      o_rem
);
    import rlfr_pkg::*;

    logic [WORD_W:0]        r_rem;
    logic [WORD_W-1:0]      r_dvd;
    logic [WORD_W-1:0]      r_dvs;
    logic [DIV_CNT_W-1:0]   r_cnt;
    logic                   r_done;
    logic [WORD_W:0]        shifted;
    logic [WORD_W:0]        n_rem;

    // one restoring step per cycle, msb first
    always_comb begin
        shifted = {r_rem[WORD_W-1:0], r_dvd[WORD_W-1]};
        if (shifted >= {1'b0, r_dvs}) begin
            n_rem = shifted - {1'b0, r_dvs};
        end else begin
            n_rem = shifted;
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_start) begin
            r_rem <= '0;
            r_dvd <= i_dividend;
            r_dvs <= i_divisor;
        end else if (r_cnt != '0) begin
            r_rem <= n_rem;
            r_dvd <= r_dvd << 1;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_cnt  <= '0;
            r_done <= 1'b0;
        end else begin
            r_done <= (r_cnt == DIV_CNT_W'(1)) && !i_start;
            if (i_start) begin
                r_cnt <= DIV_CNT_W'(WORD_W);
            end else if (r_cnt != '0) begin
                r_cnt <= r_cnt - DIV_CNT_W'(1);
            end
        end
    end

    assign o_done = r_done;
    assign o_rem  = r_rem[WORD_W-1:0];

endmodule
`default_nettype wire

FILE: src/rlfr_ring.sv
`timescale 1ns / 1ps
`default_nettype none
module rlfr_ring (
    input  wire logic            i_clk,
    input  wire logic            i_rst_n,
    input  wire logic            i_q_valid,
    input  wire rlfr_pkg::t_item i_q_item,
    output logic                 o_q_pop,
    output logic                 o_result_valid,
    output logic [31:0]          o_word,
    output logic [31:0]          o_bounded,
    output logic                 o_bound_zero
);
    import rlfr_pkg::*;

    localparam logic [2:0] ST_IDLE = 3'd0;
    localparam logic [2:0] ST_SEED = 3'd1;
    localparam logic [2:0] ST_READ = 3'd2;
    localparam logic [2:0] ST_CALC = 3'd3;
    localparam logic [2:0] ST_DIV  = 3'd4;

    logic [WORD_W-1:0]     r_mem [RING_WORDS];
    logic [RING_WORDS-1:0] r_mem_ok;

    logic [2:0]            r_state, n_state;
    t_item                 r_item;
    logic [WORD_W-1:0]     r_seed;
    logic [PTR_W-1:0]      r_idx;
    logic [PTR_W-1:0]      r_first, r_second;
    logic [WORD_W-1:0]     r_rd_first, r_rd_second;
    logic                  r_ok_first, r_ok_second;
    logic                  r_out_valid;
    logic [WORD_W-1:0]     r_word;
    logic [WORD_W-1:0]     r_bounded;
    logic                  r_bound_zero;

    logic                  mem_we;
    logic [PTR_W-1:0]      mem_waddr;
    logic [WORD_W-1:0]     mem_wdata;
    logic [WORD_W-1:0]     seed_next;
    logic [WORD_W-1:0]     draw_word;
    logic                  div_start;
    logic                  div_done;
    logic [WORD_W-1:0]     div_rem;

    assign seed_next = r_seed * SEED_MULT + WORD_W'(1);
    // entries never written read as zero
    assign draw_word = rot_left(r_ok_second ? r_rd_second : '0)
                     + rot_right(r_ok_first ? r_rd_first : '0);

    always_comb begin
        n_state   = r_state;
        o_q_pop   = 1'b0;
        mem_we    = 1'b0;
        mem_waddr = r_first;
        mem_wdata = draw_word;
        div_start = 1'b0;
        unique case (r_state)
            ST_IDLE: begin
                if (i_q_valid) begin
                    o_q_pop = 1'b1;
                    n_state = i_q_item.is_draw ? ST_READ : ST_SEED;
                end
            end
            ST_SEED: begin
                mem_we    = 1'b1;
                mem_waddr = r_idx;
                mem_wdata = seed_next;
                if (r_idx == LAST_POS) begin
                    n_state = ST_IDLE;
                end
            end
            ST_READ: begin
                n_state = ST_CALC;
            end
            ST_CALC: begin
                mem_we = 1'b1;
                if (r_item.bound_zero) begin
                    n_state = ST_IDLE;
                end else begin
                    div_start = 1'b1;
                    n_state   = ST_DIV;
                end
            end
            ST_DIV: begin
                if (div_done) begin
                    n_state = ST_IDLE;
                end
            end
            default: begin
                n_state = ST_IDLE;
            end
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (mem_we) begin
            r_mem[mem_waddr] <= mem_wdata;
        end
        if (r_state == ST_READ) begin
            r_rd_first  <= r_mem[r_first];
            r_rd_second <= r_mem[r_second];
        end
    end

    always_ff @(posedge i_clk) begin
        if (o_q_pop) begin
            r_item <= i_q_item;
            r_seed <= i_q_item.data;
        end else if (r_state == ST_SEED) begin
            r_seed <= seed_next;
        end
        if (r_state == ST_CALC) begin
            r_word <= draw_word;
        end
        if (r_state == ST_CALC && r_item.bound_zero) begin
            r_bounded    <= '0;
            r_bound_zero <= 1'b1;
        end else if (r_state == ST_DIV && div_done) begin
            r_bounded    <= div_rem;
            r_bound_zero <= 1'b0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state     <= ST_IDLE;
            r_mem_ok    <= '0;
            r_idx       <= '0;
            r_first     <= FIRST_INIT;
            r_second    <= SECOND_INIT;
            r_ok_first  <= 1'b0;
            r_ok_second <= 1'b0;
            r_out_valid <= 1'b0;
        end else begin
            r_state     <= n_state;
            r_out_valid <= (r_state == ST_CALC && r_item.bound_zero)
                        || (r_state == ST_DIV && div_done);
            if (mem_we) begin
                r_mem_ok[mem_waddr] <= 1'b1;
            end
            if (r_state == ST_IDLE) begin
                r_idx <= '0;
            end else if (r_state == ST_SEED) begin
                r_idx <= r_idx + PTR_W'(1);
            end
            if (r_state == ST_SEED && r_idx == LAST_POS) begin
                r_first  <= FIRST_INIT;
                r_second <= SECOND_INIT;
            end else if (r_state == ST_CALC) begin
                r_first  <= step_down(r_first);
                r_second <= step_down(r_second);
            end
            if (r_state == ST_READ) begin
                r_ok_first  <= r_mem_ok[r_first];
                r_ok_second <= r_mem_ok[r_second];
            end
        end
    end

    rlfr_div u_div (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_start    (div_start),
        .i_dividend (draw_word),
        .i_divisor  (r_item.data),
        .o_done     (div_done),
        .o_rem      (div_rem)
    );

    assign o_result_valid = r_out_valid;
    assign o_word         = r_word;
    assign o_bounded      = r_bounded;
    assign o_bound_zero   = r_bound_zero;

endmodule
`default_nettype wire

FILE: src/rotate_lagged_fibonacci_rng_top.sv
// Random word generator built on a rotating lagged-Fibonacci ring of 17 words.
// Pulse start with command 0 to reseed from seed_value, or with command 1 to
// draw one word; a request is taken whenever busy is low. A small two-entry
// request queue sits in front of the ring engine, so busy only rises when two
// requests are already waiting. A reseed writes one ring word per cycle and
// gives no result. A draw first reads the ring and then updates it; after that
// the word modulo bound comes from a one-bit-per-cycle divider. With a zero
// bound no division is started, and the draw finishes right after the
// ring update and sets bound_zero. Each result shows on o_word, o_bounded and
// o_bound_zero for exactly one cycle with o_result_valid high and cannot be
// held off, so capture it then. The ring starts out all zero: reseed first.
`timescale 1ns / 1ps
`default_nettype none
module rotate_lagged_fibonacci_rng_top (
    input  wire logic        i_clk,
    input  wire logic        i_rst_n,
    input  wire logic        start,
    output logic             busy,
    input  wire logic        i_command,
    input  wire logic [31:0] i_seed_value,
    input  wire logic [31:0] i_bound,
    output logic             o_result_valid,
    output logic [31:0]      o_word,
    output logic [31:0]      o_bounded,
    output logic             o_bound_zero
);
    import rlfr_pkg::*;

    logic  q_valid;
    t_item q_item;
    logic  q_pop;

    rlfr_front u_front (
        .i_clk        (i_clk),
        .i_rst_n      (i_rst_n),
        .start        (start),
        .busy         (busy),
        .i_command    (i_command),
        .i_seed_value (i_seed_value),
        .i_bound      (i_bound),
        .o_q_valid    (q_valid),
        .o_q_item     (q_item),
        .i_q_pop      (q_pop)
    );

    rlfr_ring u_ring (
        .i_clk          (i_clk),
        .i_rst_n        (i_rst_n),
        .i_q_valid      (q_valid),
        .i_q_item       (q_item),
        .o_q_pop        (q_pop),
        .o_result_valid (o_result_valid),
        .o_word         (o_word),
        .o_bounded      (o_bounded),
        .o_bound_zero   (o_bound_zero)
    );

endmodule
`default_nettype wire

FILE: src/rlfr_checker.sv
`timescale 1ns / 1ps
`default_nettype none
module rlfr_checker (
    input  wire logic        i_clk,
    input  wire logic        i_rst_n,
    input  wire logic        start,
    input  wire logic        busy,
    input  wire logic        o_result_valid,
    input  wire logic [31:0] o_bounded,
    input  wire logic        o_bound_zero
);

    // a draw needs at least a read and an update, so results never come back to back
    a_no_double_result: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_result_valid |=> !o_result_valid)
        else $error("result strobe on two consecutive cycles");

    a_zero_bound_result: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (o_result_valid && o_bound_zero) |-> (o_bounded == 32'd0))
        else $error("bounded not zero with bound_zero set");

    a_reset_empty: assert property (@(posedge i_clk)
        !i_rst_n |=> (!busy && !o_result_valid))
        else $error("queue or result not cleared by reset");

    // a single request into an empty queue cannot fill it
    a_one_request_no_busy: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        ($past(!i_rst_n) && start) |=> !busy)
        else $error("busy after a single request following reset");

endmodule

bind rotate_lagged_fibonacci_rng_top rlfr_checker u_rlfr_checker (
    .i_clk          (i_clk),
    .i_rst_n        (i_rst_n),
    .start          (start),
    .busy           (busy),
    .o_result_valid (o_result_valid),
    .o_bounded      (o_bounded),
    .o_bound_zero   (o_bound_zero)
);
`default_nettype wire
